>>> rtl/hsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heightmap smoothing filter.
// No dependencies.
package hsf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  // Compare width for column arithmetic: holds the width register and MAX_WIDTH.
  localparam int CMP_W     = (COL_W + 1 > 11) ? COL_W + 1 : 11;
  localparam int ROW_W     = 17;   // one past height during the final flush
  localparam int PIX_W     = 8;
  localparam int SUM_W     = 12;   // ten bytes summed
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int DIV_SHIFT = 16;

  // floor(s / 10) == (s * 6554) >> 16 for every s below 2560
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;
  localparam logic [6:0]         FLAT_MASK   = 7'h7F;

  localparam logic [10:0] WIDTH_RESET  = 11'd256;
  localparam logic [15:0] HEIGHT_RESET = 16'd256;
  localparam logic [10:0] WIDTH_MIN    = 11'd3;
  localparam logic [15:0] HEIGHT_MIN   = 16'd3;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

>>> rtl/heightmap_smoothing_filter_core.sv
`timescale 1ns / 1ps
// Streaming 3x3 weighted smoothing of a raster height grid.
// Depends on hsf_pkg.
//
// Path: the transaction that completes a window moves through the stage 1,
//   window, sum and output registers; the stream itself trails the input by one
//   row and one pixel, and width + 1 drain transactions flush the tail of a grid.
// Throughput: one transaction per cycle while the result channel is not stalled,
//   set by the line buffer, which takes one read and one write-back per cycle.
// Reset (rst_n, synchronous): counters and stage valids, out_valid among them, clear;
//   width and height return to 256. The line buffer is not cleared; entries
//   reach an output only after being written.
module heightmap_smoothing_filter_core import hsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_height_in,
  input  logic [7:0]  in_flatten_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_smoothed,
  output logic        out_last_pixel,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the grid.
  // ---------------------------------------------------------------------------
  logic [10:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  width_nxt  = cfg_pwdata[10:0];
        REG_HEIGHT: height_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = {21'd0, width_r};
      REG_HEIGHT: cfg_prdata = {16'd0, height_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3.
  logic [CMP_W-1:0] w_eff;
  logic [15:0]      h_eff;

  always_comb begin
    if (width_r < WIDTH_MIN)
      w_eff = CMP_W'(WIDTH_MIN);
    else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH))
      w_eff = CMP_W'(MAX_WIDTH);
    else
      w_eff = CMP_W'(width_r);
    h_eff = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
  end

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage moves when the one after it is empty or moving.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic en2, en3, en4;

  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !s3_valid_r || en4;
  assign en2      = !s2_valid_r || en3;
  assign in_stall = s1_valid_r && !en2;

  // ---------------------------------------------------------------------------
  // Accept stage: raster position, flatten, read of the line buffer.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept, flushing, noop, enter;
  logic [CMP_W-1:0] col_inc;
  logic [ROW_W-1:0] h_ext;
  pix_t             pix_in;
  logic             emit_in, interior_in, last_in;

  assign accept   = in_valid && !in_stall;
  assign h_ext    = ROW_W'(h_eff);
  assign flushing = row_r >= h_ext;
  // drain before the grid is complete does nothing
  assign noop     = (req_t'(in_req_type) == REQ_DRAIN) && !flushing;
  assign enter    = accept && !noop;
  assign col_inc  = CMP_W'(col_r) + CMP_W'(1);

  always_comb begin
    if (flushing)
      pix_in = '0;
    else if (in_flatten_in != 8'd0)
      pix_in = {1'b0, in_flatten_in[6:0] & FLAT_MASK};
    else
      pix_in = in_height_in;
  end

  // Output position is one row and one column behind the input position.
  // It is interior only for input column >= 2 and input row in 2..h-1.
  assign emit_in     = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
  assign interior_in = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2)) && (row_r < h_ext);
  assign last_in     = (row_r == h_ext + ROW_W'(1)) && (col_r == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (enter) begin
      if (last_in) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: one entry per column holds {upper row, middle row}.
  // Read at accept, written back one stage later. The same column comes back
  // no sooner than three transactions later, after its write-back.
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] lbuf_mem [0:MAX_WIDTH-1];
  logic [2*PIX_W-1:0] rd_r;

  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_pix_r;
  logic             s1_flush_r, s1_emit_r, s1_int_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (enter)
      rd_r <= lbuf_mem[col_r];
    if (s1_valid_r && en2 && !s1_flush_r)
      lbuf_mem[s1_col_r] <= {rd_r[PIX_W-1:0], s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_col_r   <= col_r;
      s1_pix_r   <= pix_in;
      s1_flush_r <= flushing;
      s1_emit_r  <= emit_in;
      s1_int_r   <= interior_in;
      s1_last_r  <= last_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Window stage: 3x3 window shifts left, new column from the line buffer.
  // Row 0 upper, row 1 middle (holds the centre), row 2 current.
  // ---------------------------------------------------------------------------
  pix_t win_r [0:2][0:2];
  logic s2_emit_r, s2_int_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r && en2) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_r[2*PIX_W-1:PIX_W];
      win_r[1][2] <= rd_r[PIX_W-1:0];
      win_r[2][2] <= s1_pix_r;
    end
    if (en2) begin
      s2_emit_r <= s1_emit_r;
      s2_int_r  <= s1_int_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: eight neighbors plus the centre twice.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] win_sum;
  logic [SUM_W-1:0] s3_sum_r;
  pix_t             s3_centre_r;
  logic             s3_int_r, s3_last_r;

  always_comb begin
    win_sum = SUM_W'(win_r[1][1]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win_sum = win_sum + SUM_W'(win_r[i][j]);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum_r    <= win_sum;
      s3_centre_r <= win_r[1][1];
      s3_int_r    <= s2_int_r;
      s3_last_r   <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: divide by ten through the reciprocal; borders pass.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] div_prod;
  pix_t              smoothed_r;
  logic              last_r;

  assign div_prod = PROD_W'(s3_sum_r) * PROD_W'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (en4) begin
      smoothed_r <= s3_int_r ? div_prod[DIV_SHIFT +: PIX_W] : s3_centre_r;
      last_r     <= s3_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) s1_valid_r  <= enter;
      if (en2)       s2_valid_r  <= s1_valid_r;
      if (en3)       s3_valid_r  <= s2_valid_r && s2_emit_r;
      if (en4)       out_valid_r <= s3_valid_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_smoothed   = smoothed_r;
  assign out_last_pixel = last_r;

endmodule

>>> rtl/hsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the smoothing filter, bound to the top level.
// Depends on heightmap_smoothing_filter_core.
module hsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_smoothed,
  input logic       out_last_pixel
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smoothed) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  // input back-pressure only comes from a blocked result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_smoothing_filter_core hsf_checker u_hsf_checker (.*);
